>>> hdl/frsn_pkg.sv
// Shared constants and result codes for the Fresnel reflectance pipeline.
package frsn_pkg;

    // Default fraction width of the cosine and reflectance words
    localparam int FRAC_BITS_DEF = 16;

    // Internal angle arithmetic works in Q2.30
    localparam int WORK_BITS = 30;

    // Which branch produced the reflectance
    typedef enum logic [2:0] {
        CASE_MATCHED = 3'd0,
        CASE_NORMAL  = 3'd1,
        CASE_GRAZING = 3'd2,
        CASE_TIR     = 3'd3,
        CASE_GENERAL = 3'd4
    } case_code_t;

endpackage

>>> hdl/frsn_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module frsn_div #(
    parameter int NW = 62,
    parameter int DW = 32,
    parameter int QW = 30,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quot,
    output logic [SW-1:0] side_out
);

    // Caller guarantees num >> QW < den, so the partial remainder fits DW bits
    logic [QW-1:0] valid_reg;
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] low_reg  [QW];
    logic [QW-1:0] q_reg    [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] q_in;
        logic [DW-1:0] den_in;
        logic [SW-1:0] side_s;
        logic          v_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] low_next;
        logic [QW-1:0] q_next;

        if (g == 0) begin : g_first
            assign rem_in = DW'(num >> QW);
            assign low_in = num[QW-1:0];
            assign q_in   = '0;
            assign den_in = den;
            assign side_s = side_in;
            assign v_in   = in_valid;
        end else begin : g_later
            assign rem_in = rem_reg[g-1];
            assign low_in = low_reg[g-1];
            assign q_in   = q_reg[g-1];
            assign den_in = den_reg[g-1];
            assign side_s = side_reg[g-1];
            assign v_in   = valid_reg[g-1];
        end

        // shift in next numerator bit, subtract when it fits
        assign trial    = {rem_in, low_in[QW-1]};
        assign diff     = trial - {1'b0, den_in};
        assign ge       = (trial >= {1'b0, den_in});
        assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        assign low_next = low_in << 1;
        assign q_next   = {q_in[QW-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else
            begin
                valid_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g]  <= rem_next;
            low_reg[g]  <= low_next;
            q_reg[g]    <= q_next;
            den_reg[g]  <= den_in;
            side_reg[g] <= side_s;
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quot      = q_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

>>> hdl/frsn_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module frsn_sqrt #(
    parameter int RW = 30,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [2*RW-1:0] rad,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [RW-1:0]   root,
    output logic [SW-1:0]   side_out
);

    logic [RW-1:0]   valid_reg;
    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [2*RW-1:0] rad_reg  [RW];
    logic [SW-1:0]   side_reg [RW];

    for (genvar g = 0; g < RW; g++) begin : g_stage
        logic [RW+1:0]   rem_in;
        logic [RW-1:0]   root_in;
        logic [2*RW-1:0] rad_in;
        logic [SW-1:0]   side_s;
        logic            v_in;
        logic [RW+3:0]   cur;
        logic [RW+3:0]   trial;
        logic [RW+3:0]   diff;
        logic            ge;
        logic [RW+1:0]   rem_next;
        logic [RW-1:0]   root_next;
        logic [2*RW-1:0] rad_next;

        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
            assign side_s  = side_in;
            assign v_in    = in_valid;
        end else begin : g_later
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign rad_in  = rad_reg[g-1];
            assign side_s  = side_reg[g-1];
            assign v_in    = valid_reg[g-1];
        end

        // bring down two radicand bits, try 4*root+1
        assign cur       = {rem_in, rad_in[2*RW-1 -: 2]};
        assign trial     = {2'b00, root_in, 2'b01};
        assign diff      = cur - trial;
        assign ge        = (cur >= trial);
        assign rem_next  = ge ? diff[RW+1:0] : cur[RW+1:0];
        assign root_next = {root_in[RW-2:0], ge};
        assign rad_next  = rad_in << 2;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else
            begin
                valid_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g]  <= rem_next;
            root_reg[g] <= root_next;
            rad_reg[g]  <= rad_next;
            side_reg[g] <= side_s;
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule

>>> hdl/fresnel_reflectance.sv
// Unpolarized Fresnel reflectance, fully pipelined.
//
// Input word: index_from, index_to (unsigned Q2.14) and cos_incident
// (unsigned Q1.FRAC_BITS), taken at a rising edge with start high and busy
// low. busy is always low: a new word may enter on every cycle.
// Result word: reflectance (Q1.FRAC_BITS, at most 1.0) and case_taken, shown
// for exactly one cycle with done high.
// The pipeline is the chain of bit-per-stage units: the normal-incidence
// divider (FRAC_BITS+1 stages), two 30-stage square roots, the 30-stage sine
// ratio divider and the 30-stage reflectance ratio dividers, plus ten
// arithmetic stages. Throughput is one word per cycle.
// All cases run through the same pipeline; the branch is picked at the end.
// Reset clears every valid bit, so no stray done follows reset; words in
// flight at reset are dropped. The receiver cannot stall, so nothing in the
// pipeline ever holds.
module fresnel_reflectance
    import frsn_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [15:0]          index_from,
    input  logic [15:0]          index_to,
    input  logic [FRAC_BITS:0]   cos_incident,
    output logic                 done,
    output logic [FRAC_BITS:0]   reflectance,
    output logic [2:0]           case_taken
);

    localparam int F  = FRAC_BITS;
    localparam int W  = WORK_BITS;
    localparam int NN = 33 + F;
    localparam int PW = 2 * W + 2;

    localparam logic [W:0]    K_ONE   = {1'b1, {W{1'b0}}};
    localparam logic [F:0]    ONE     = {1'b1, {F{1'b0}}};
    localparam logic [PW-1:0] HALF_Q  = PW'(1) << (W - 1);
    localparam logic [PW:0]   RND_OUT = (PW + 1)'(1) << (60 - F);

    typedef struct packed {
        logic matched;
        logic normal;
        logic graze;
    } kind_t;

    typedef struct packed {
        logic [15:0]    n1;
        logic [15:0]    n2;
        logic [W-1:0]   c1;
        kind_t          kind;
        logic [2*W-1:0] rad1;
    } side_nd_t;

    typedef struct packed {
        logic [15:0]  n1;
        logic [15:0]  n2;
        logic [W-1:0] c1;
        kind_t        kind;
        logic [F:0]   rnorm;
    } side_s1_t;

    typedef struct packed {
        logic [W-1:0] c1;
        logic [W-1:0] s1;
        kind_t        kind;
        logic         tir;
        logic [F:0]   rnorm;
    } side_d2_t;

    typedef struct packed {
        logic [W-1:0] s1;
        logic [W-1:0] s2;
        logic [W-1:0] c1;
        kind_t        kind;
        logic         tir;
        logic         z2;
        logic [F:0]   rnorm;
    } side_s2_t;

    typedef struct packed {
        kind_t      kind;
        logic       tir;
        logic       sa;
        logic [F:0] rnorm;
    } side_ra_t;

    assign busy = 1'b0;

    // ---- stage A: capture input word
    logic          valid_a_reg;
    logic [15:0]   n1_a_reg;
    logic [15:0]   n2_a_reg;
    logic [F:0]    c_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        n1_a_reg <= index_from;
        n2_a_reg <= index_to;
        c_a_reg  <= cos_incident;
    end

    // ---- stage B: case flags, index sum/difference, cosine to Q30
    kind_t        kind_b_next;
    logic [15:0]  d_b_next;
    logic [16:0]  s_b_next;
    logic [W-1:0] c1_b_next;

    assign kind_b_next.matched = (n1_a_reg == n2_a_reg);
    assign kind_b_next.normal  = c_a_reg[F];
    assign kind_b_next.graze   = (c_a_reg == '0);
    assign d_b_next  = (n2_a_reg >= n1_a_reg) ? (n2_a_reg - n1_a_reg) : (n1_a_reg - n2_a_reg);
    assign s_b_next  = {1'b0, n1_a_reg} + {1'b0, n2_a_reg};
    assign c1_b_next = W'(c_a_reg[F-1:0]) << (W - F);

    logic         valid_b_reg;
    kind_t        kind_b_reg;
    logic [15:0]  d_b_reg;
    logic [16:0]  s_b_reg;
    logic [W-1:0] c1_b_reg;
    logic [15:0]  n1_b_reg;
    logic [15:0]  n2_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_b_reg <= kind_b_next;
        d_b_reg    <= d_b_next;
        s_b_reg    <= s_b_next;
        c1_b_reg   <= c1_b_next;
        n1_b_reg   <= n1_a_reg;
        n2_b_reg   <= n2_a_reg;
    end

    // ---- stage C: squares; sin^2 radicand wraps K^2 to zero mod 2^60
    logic [31:0]    dsq_c;
    logic [33:0]    ssq_c_next;
    logic [2*W-1:0] c1sq_c;
    logic [NN-1:0]  nnum_c_next;
    logic [2*W-1:0] rad1_c_next;

    assign dsq_c       = d_b_reg * d_b_reg;
    assign ssq_c_next  = s_b_reg * s_b_reg;
    assign c1sq_c      = c1_b_reg * c1_b_reg;
    assign nnum_c_next = (NN'(dsq_c) << F) + NN'(ssq_c_next >> 1);
    assign rad1_c_next = (2 * W)'(0) - c1sq_c;

    logic          valid_c_reg;
    logic [NN-1:0] nnum_c_reg;
    logic [33:0]   ssq_c_reg;
    side_nd_t      side_nd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_c_reg <= 1'b0;
        end
        else
        begin
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        nnum_c_reg       <= nnum_c_next;
        ssq_c_reg        <= ssq_c_next;
        side_nd_reg.n1   <= n1_b_reg;
        side_nd_reg.n2   <= n2_b_reg;
        side_nd_reg.c1   <= c1_b_reg;
        side_nd_reg.kind <= kind_b_reg;
        side_nd_reg.rad1 <= rad1_c_next;
    end

    // ---- normal-incidence ratio, rounded half up
    logic       valid_nd;
    logic [F:0] rnorm_nd;
    side_nd_t   side_nd_out;

    frsn_div #(
        .NW(NN),
        .DW(34),
        .QW(F + 1),
        .SW($bits(side_nd_t))
    ) u_div_normal (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_c_reg),
        .num      (nnum_c_reg),
        .den      (ssq_c_reg),
        .side_in  (side_nd_reg),
        .out_valid(valid_nd),
        .quot     (rnorm_nd),
        .side_out (side_nd_out)
    );

    // ---- s1 = sqrt(K^2 - c1^2)
    side_s1_t     side_s1_in;
    side_s1_t     side_s1_out;
    logic         valid_s1;
    logic [W-1:0] s1_root;

    assign side_s1_in.n1    = side_nd_out.n1;
    assign side_s1_in.n2    = side_nd_out.n2;
    assign side_s1_in.c1    = side_nd_out.c1;
    assign side_s1_in.kind  = side_nd_out.kind;
    assign side_s1_in.rnorm = rnorm_nd;

    frsn_sqrt #(
        .RW(W),
        .SW($bits(side_s1_t))
    ) u_sqrt_sin1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_nd),
        .rad      (side_nd_out.rad1),
        .side_in  (side_s1_in),
        .out_valid(valid_s1),
        .root     (s1_root),
        .side_out (side_s1_out)
    );

    // ---- stage E: n1 * s1
    logic [W+15:0] num2_e_next;

    assign num2_e_next = side_s1_out.n1 * s1_root;

    logic          valid_e_reg;
    logic [W+15:0] num2_e_reg;
    logic [15:0]   n2_e_reg;
    logic [W-1:0]  s1_e_reg;
    side_s1_t      side_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_e_reg <= 1'b0;
        end
        else
        begin
            valid_e_reg <= valid_s1;
        end
    end

    always_ff @(posedge clk)
    begin
        num2_e_reg <= num2_e_next;
        n2_e_reg   <= side_s1_out.n2;
        s1_e_reg   <= s1_root;
        side_e_reg <= side_s1_out;
    end

    // total internal reflection when n1*s1 >= n2*K (zero n2 included)
    side_d2_t     side_d2_in;
    side_d2_t     side_d2_out;
    logic         valid_d2;
    logic [W-1:0] s2_quot;

    assign side_d2_in.c1    = side_e_reg.c1;
    assign side_d2_in.s1    = s1_e_reg;
    assign side_d2_in.kind  = side_e_reg.kind;
    assign side_d2_in.tir   = (n2_e_reg == '0) || (num2_e_reg[W+15:W] >= n2_e_reg);
    assign side_d2_in.rnorm = side_e_reg.rnorm;

    frsn_div #(
        .NW(W + 16),
        .DW(16),
        .QW(W),
        .SW($bits(side_d2_t))
    ) u_div_sin2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_e_reg),
        .num      (num2_e_reg),
        .den      (n2_e_reg),
        .side_in  (side_d2_in),
        .out_valid(valid_d2),
        .quot     (s2_quot),
        .side_out (side_d2_out)
    );

    // ---- stage F: cos^2 radicand for the transmitted angle
    logic [2*W-1:0] s2sq_f;

    assign s2sq_f = s2_quot * s2_quot;

    logic           valid_f_reg;
    logic [2*W-1:0] rad2_f_reg;
    side_s2_t       side_f_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_f_reg <= 1'b0;
        end
        else
        begin
            valid_f_reg <= valid_d2;
        end
    end

    always_ff @(posedge clk)
    begin
        rad2_f_reg       <= (2 * W)'(0) - s2sq_f;
        side_f_reg.s1    <= side_d2_out.s1;
        side_f_reg.s2    <= s2_quot;
        side_f_reg.c1    <= side_d2_out.c1;
        side_f_reg.kind  <= side_d2_out.kind;
        side_f_reg.tir   <= side_d2_out.tir;
        side_f_reg.z2    <= (s2_quot == '0);
        side_f_reg.rnorm <= side_d2_out.rnorm;
    end

    // ---- c2 = sqrt(K^2 - s2^2)
    side_s2_t     side_s2_out;
    logic         valid_s2;
    logic [W-1:0] c2_root;

    frsn_sqrt #(
        .RW(W),
        .SW($bits(side_s2_t))
    ) u_sqrt_cos2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_f_reg),
        .rad      (rad2_f_reg),
        .side_in  (side_f_reg),
        .out_valid(valid_s2),
        .root     (c2_root),
        .side_out (side_s2_out)
    );

    // ---- stage G: angle products (zero s2 means c2 is exactly K)
    logic [W:0]     c2_g;
    logic [2*W:0]   psc_g_next;
    logic [2*W:0]   pcs_g_next;
    logic [2*W:0]   pcc_g_next;
    logic [2*W:0]   pss_g_next;

    assign c2_g       = side_s2_out.z2 ? K_ONE : {1'b0, c2_root};
    assign psc_g_next = side_s2_out.s1 * c2_g;
    assign pcs_g_next = side_s2_out.c1 * side_s2_out.s2;
    assign pcc_g_next = side_s2_out.c1 * c2_g;
    assign pss_g_next = side_s2_out.s1 * side_s2_out.s2;

    logic         valid_g_reg;
    logic [2*W:0] psc_g_reg;
    logic [2*W:0] pcs_g_reg;
    logic [2*W:0] pcc_g_reg;
    logic [2*W:0] pss_g_reg;
    kind_t        kind_g_reg;
    logic         tir_g_reg;
    logic [F:0]   rnorm_g_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_g_reg <= 1'b0;
        end
        else
        begin
            valid_g_reg <= valid_s2;
        end
    end

    always_ff @(posedge clk)
    begin
        psc_g_reg   <= psc_g_next;
        pcs_g_reg   <= pcs_g_next;
        pcc_g_reg   <= pcc_g_next;
        pss_g_reg   <= pss_g_next;
        kind_g_reg  <= side_s2_out.kind;
        tir_g_reg   <= side_s2_out.tir;
        rnorm_g_reg <= side_s2_out.rnorm;
    end

    // ---- stage H: sin/cos of sum and difference, rounded to Q30
    logic [PW-1:0] am_sum;
    logic [PW-1:0] ap_sum;
    logic [PW-1:0] cm_sum;
    logic [PW-1:0] cp_sum;

    assign am_sum = ((psc_g_reg >= pcs_g_reg) ? PW'(psc_g_reg - pcs_g_reg)
                                              : PW'(pcs_g_reg - psc_g_reg)) + HALF_Q;
    assign ap_sum = PW'(psc_g_reg) + PW'(pcs_g_reg) + HALF_Q;
    assign cm_sum = PW'(pcc_g_reg) + PW'(pss_g_reg) + HALF_Q;
    assign cp_sum = ((pcc_g_reg >= pss_g_reg) ? PW'(pcc_g_reg - pss_g_reg)
                                              : PW'(pss_g_reg - pcc_g_reg)) + HALF_Q;

    logic         valid_h_reg;
    logic [W+1:0] am_h_reg;
    logic [W+1:0] ap_h_reg;
    logic [W+1:0] cm_h_reg;
    logic [W+1:0] cp_h_reg;
    kind_t        kind_h_reg;
    logic         tir_h_reg;
    logic [F:0]   rnorm_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_h_reg <= 1'b0;
        end
        else
        begin
            valid_h_reg <= valid_g_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        am_h_reg    <= am_sum[PW-1:W];
        ap_h_reg    <= ap_sum[PW-1:W];
        cm_h_reg    <= cm_sum[PW-1:W];
        cp_h_reg    <= cp_sum[PW-1:W];
        kind_h_reg  <= kind_g_reg;
        tir_h_reg   <= tir_g_reg;
        rnorm_h_reg <= rnorm_g_reg;
    end

    // ---- ratios am/ap and cp/cm; numerator >= denominator saturates at K
    side_ra_t     side_ra_in;
    side_ra_t     side_ra_out;
    logic         sc_in;
    logic         sc_out;
    logic         valid_ra;
    logic         valid_rc;
    logic [W-1:0] qa;
    logic [W-1:0] qc;

    assign side_ra_in.kind  = kind_h_reg;
    assign side_ra_in.tir   = tir_h_reg;
    assign side_ra_in.sa    = (am_h_reg >= ap_h_reg);
    assign side_ra_in.rnorm = rnorm_h_reg;
    assign sc_in            = (cp_h_reg >= cm_h_reg);

    frsn_div #(
        .NW(PW),
        .DW(W + 2),
        .QW(W),
        .SW($bits(side_ra_t))
    ) u_div_ratio_sin (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_h_reg),
        .num      ({am_h_reg, W'(0)}),
        .den      (ap_h_reg),
        .side_in  (side_ra_in),
        .out_valid(valid_ra),
        .quot     (qa),
        .side_out (side_ra_out)
    );

    frsn_div #(
        .NW(PW),
        .DW(W + 2),
        .QW(W),
        .SW(1)
    ) u_div_ratio_cos (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_h_reg),
        .num      ({cp_h_reg, W'(0)}),
        .den      (cm_h_reg),
        .side_in  (sc_in),
        .out_valid(valid_rc),
        .quot     (qc),
        .side_out (sc_out)
    );

    // ---- stage I: square both ratios
    logic [W:0]    ra_i;
    logic [W:0]    rc_i;
    logic [PW-1:0] rasq_i;
    logic [PW-1:0] rcsq_i;

    assign ra_i   = side_ra_out.sa ? K_ONE : {1'b0, qa};
    assign rc_i   = sc_out ? K_ONE : {1'b0, qc};
    assign rasq_i = ra_i * ra_i + HALF_Q;
    assign rcsq_i = rc_i * rc_i + HALF_Q;

    logic       valid_i_reg;
    logic [W:0] a2_i_reg;
    logic [W:0] c2q_i_reg;
    kind_t      kind_i_reg;
    logic       tir_i_reg;
    logic [F:0] rnorm_i_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_i_reg <= 1'b0;
        end
        else
        begin
            valid_i_reg <= valid_ra & valid_rc;
        end
    end

    always_ff @(posedge clk)
    begin
        a2_i_reg    <= rasq_i[2*W:W];
        c2q_i_reg   <= rcsq_i[2*W:W];
        kind_i_reg  <= side_ra_out.kind;
        tir_i_reg   <= side_ra_out.tir;
        rnorm_i_reg <= side_ra_out.rnorm;
    end

    // ---- stage J: a2 * (K + c2q)
    logic [W+1:0] ksum_j;
    logic [PW:0]  prod_j_next;

    assign ksum_j      = {1'b0, K_ONE} + {1'b0, c2q_i_reg};
    assign prod_j_next = a2_i_reg * ksum_j;

    logic        valid_j_reg;
    logic [PW:0] prod_j_reg;
    kind_t       kind_j_reg;
    logic        tir_j_reg;
    logic [F:0]  rnorm_j_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_j_reg <= 1'b0;
        end
        else
        begin
            valid_j_reg <= valid_i_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_j_reg  <= prod_j_next;
        kind_j_reg  <= kind_i_reg;
        tir_j_reg   <= tir_i_reg;
        rnorm_j_reg <= rnorm_i_reg;
    end

    // ---- output stage: round, saturate, pick the branch
    logic [PW:0] rsum_k;
    logic [F:0]  rgen_k;
    logic [F:0]  refl_next;
    case_code_t  case_next;

    assign rsum_k = prod_j_reg + RND_OUT;
    assign rgen_k = rsum_k[2*W+1 -: F+1];

    always_comb
    begin
        if (kind_j_reg.matched)
        begin
            refl_next = '0;
            case_next = CASE_MATCHED;
        end
        else if (kind_j_reg.normal)
        begin
            refl_next = rnorm_j_reg;
            case_next = CASE_NORMAL;
        end
        else if (kind_j_reg.graze)
        begin
            refl_next = ONE;
            case_next = CASE_GRAZING;
        end
        else if (tir_j_reg)
        begin
            refl_next = ONE;
            case_next = CASE_TIR;
        end
        else
        begin
            refl_next = (rgen_k > ONE) ? ONE : rgen_k;
            case_next = CASE_GENERAL;
        end
    end

    logic       done_reg;
    logic [F:0] refl_reg;
    logic [2:0] case_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_j_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        refl_reg <= refl_next;
        case_reg <= case_next;
    end

    assign done        = done_reg;
    assign reflectance = refl_reg;
    assign case_taken  = case_reg;

endmodule

>>> hdl/frsn_checker.sv
// Port-level checks for the reflectance pipeline, bound to the top level.
module frsn_checker
    import frsn_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [FRAC_BITS:0] reflectance,
    input logic [2:0]         case_taken
);

    localparam int          LATENCY = FRAC_BITS + 4 * WORK_BITS + 11;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // every accepted word comes back after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("accepted word did not return after pipeline latency");

    // matched media never reflect
    a_matched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (case_taken == CASE_MATCHED) |-> reflectance == '0)
        else $error("matched case with nonzero reflectance");

    // grazing and total internal reflection reflect fully
    a_full_reflect: assert property (@(posedge clk) disable iff (!rst_n)
        done && ((case_taken == CASE_GRAZING) || (case_taken == CASE_TIR))
        |-> reflectance == ONE)
        else $error("grazing or TIR word not at full reflectance");

    // saturation holds on every word
    a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> reflectance <= ONE)
        else $error("reflectance above one");

endmodule

bind fresnel_reflectance frsn_checker #(
    .FRAC_BITS(FRAC_BITS)
) u_frsn_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .reflectance(reflectance),
    .case_taken (case_taken)
);

>>> test/testbench.sv
// Testbench for fresnel_reflectance: directed and random words checked against a predictor.
module testbench
    import frsn_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = FRAC_BITS_DEF;
    localparam int LATENCY = FB + 131;
    localparam int STALL_LIMIT = 4000;
    localparam longint unsigned ONE = 64'd1 << FB;
    localparam longint unsigned KQ = 64'd1 << WORK_BITS;

    typedef struct packed {
        logic [FB:0] refl;
        case_code_t  code;
    } refl_word_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic [15:0]   index_from;
    logic [15:0]   index_to;
    logic [FB:0]   cos_incident;
    logic          done;
    logic [FB:0]   reflectance;
    logic [2:0]    case_taken;

    refl_word_t    expected_q[$];
    int            mismatches = 0;
    int            idle_cycles = 0;

    fresnel_reflectance #(.FRAC_BITS(FB)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .index_from(index_from), .index_to(index_to), .cos_incident(cos_incident),
        .done(done), .reflectance(reflectance), .case_taken(case_taken)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Bit-by-bit integer square root, floor
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned round_q30(input longint unsigned x);
        return (x + (64'd1 << (WORK_BITS - 1))) >> WORK_BITS;
    endfunction

    function automatic longint unsigned clipped_ratio(input longint unsigned num,
                                                      input longint unsigned den);
        longint unsigned q;
        if (den == 0)
            return KQ;
        q = (num * KQ) / den;
        return (q > KQ) ? KQ : q;
    endfunction

    function automatic longint unsigned abs_diff(input longint unsigned a,
                                                 input longint unsigned b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Expected reflectance and branch for one input word
    function automatic refl_word_t predict_reflectance(input logic [15:0] n1_in,
                                                       input logic [15:0] n2_in,
                                                       input logic [FB:0] c_in);
        refl_word_t w;
        longint unsigned n1, n2, c, d, s, sq, c1, s1, s2, c2;
        longint unsigned am, ap, cm, cp, ra, rc, a2, c2q, r;
        n1 = n1_in;
        n2 = n2_in;
        c = c_in;
        if (n1 == n2)
        begin
            w.refl = '0;
            w.code = CASE_MATCHED;
        end
        else if (c >= ONE)
        begin
            d = abs_diff(n2, n1);
            s = n2 + n1;
            sq = s * s;
            r = (((d * d) << FB) + sq / 2) / sq;
            w.refl = r[FB:0];
            w.code = CASE_NORMAL;
        end
        else if (c == 0)
        begin
            w.refl = ONE[FB:0];
            w.code = CASE_GRAZING;
        end
        else
        begin
            c1 = c << (WORK_BITS - FB);
            s1 = int_sqrt(KQ * KQ - c1 * c1);
            s2 = (n2 == 0) ? KQ : (n1 * s1) / n2;
            if (s2 >= KQ)
            begin
                w.refl = ONE[FB:0];
                w.code = CASE_TIR;
            end
            else
            begin
                c2 = int_sqrt(KQ * KQ - s2 * s2);
                am = round_q30(abs_diff(s1 * c2, c1 * s2));
                ap = round_q30(s1 * c2 + c1 * s2);
                cm = round_q30(c1 * c2 + s1 * s2);
                cp = round_q30(abs_diff(c1 * c2, s1 * s2));
                ra = clipped_ratio(am, ap);
                rc = clipped_ratio(cp, cm);
                a2 = round_q30(ra * ra);
                c2q = round_q30(rc * rc);
                r = (a2 * (KQ + c2q) + (64'd1 << (60 - FB))) >> (61 - FB);
                if (r > ONE)
                    r = ONE;
                w.refl = r[FB:0];
                w.code = CASE_GENERAL;
            end
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Drive one word after a random gap; start stays high across back-to-back words
    task automatic send_word(input logic [15:0] n1, input logic [15:0] n2,
                             input logic [FB:0] c);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        index_from = n1;
        index_to = n2;
        cos_incident = c;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_q.insert(expected_q.size(), predict_reflectance(n1, n2, c));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        refl_word_t e;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
                report_mismatch("result with no word outstanding");
            else
            begin
                e = expected_q.pop_front();
                if (reflectance !== e.refl)
                    report_mismatch($sformatf("reflectance %0d, expected %0d",
                                              reflectance, e.refl));
                if (case_taken !== e.code)
                    report_mismatch($sformatf("case_taken %0d, expected %0d",
                                              case_taken, e.code));
            end
        end
    end

    // Watchdog on cycles without any accepted word or result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic test_directed();
        send_word(16'd16384, 16'd16384, 17'd30000);     // matched
        send_word(16'd0, 16'd0, 17'd0);                 // matched at zero
        send_word(16'd16384, 16'd24576, 17'd65536);     // normal
        send_word(16'd65535, 16'd16384, 17'd65536);
        send_word(16'd16384, 16'd65535, 17'h1FFFF);     // cosine above one
        send_word(16'd0, 16'd65535, 17'd65536);
        send_word(16'd16384, 16'd21845, 17'd0);         // grazing
        send_word(16'd65535, 16'd16384, 17'd1000);      // total internal reflection
        send_word(16'd24576, 16'd16384, 17'd20000);
        send_word(16'd16384, 16'd0, 17'd40000);         // zero transmitting index
        send_word(16'd16384, 16'd24576, 17'd1);         // general, near grazing
        send_word(16'd16384, 16'd24576, 17'd65535);     // general, near normal
        send_word(16'd24576, 16'd16384, 17'd65535);
        send_word(16'd65535, 16'd16384, 17'd65535);
        send_word(16'd0, 16'd16384, 17'd30000);         // zero incident index
        send_word(16'd16384, 16'd65535, 17'd32768);
        send_word(16'd65535, 16'd65534, 17'd12345);
        send_word(16'hFFFF, 16'h0000, 17'h10000);
    endtask

    task automatic test_random(input int count);
        logic [15:0] n1, n2;
        logic [FB:0] c;
        for (int i = 0; i < count; i++)
        begin
            n1 = 16'($urandom_range(16384, 65535));
            n2 = 16'($urandom_range(16384, 65535));
            c = (FB + 1)'($urandom_range(1, 65535));
            case ($urandom_range(0, 19))
                0: n2 = n1;
                1: c = '0;
                2: c = (FB + 1)'($urandom_range(65536, 131071));
                3:
                begin
                    n1 = 16'($urandom);
                    n2 = 16'($urandom);
                    c = (FB + 1)'($urandom);
                end
                4: n2 = n1 + 16'($urandom_range(1, 64));
                5: if ($urandom_range(0, 1)) n1 = 0; else n2 = 0;
                default: ;
            endcase
            send_word(n1, n2, c);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        index_from = '0;
        index_to = '0;
        cos_incident = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(700);
        wait_drained();
        test_random(700);
        wait_drained();
        repeat (LATENCY + 20) @(negedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

>>> files.f
hdl/frsn_pkg.sv
hdl/frsn_div.sv
hdl/frsn_sqrt.sv
hdl/fresnel_reflectance.sv
hdl/frsn_checker.sv
test/testbench.sv
